>>> hdl/speed_command_frame_parser_macros.svh
// Assertion macros used by the checker file.
`ifndef SPEED_COMMAND_FRAME_PARSER_MACROS_SVH
`define SPEED_COMMAND_FRAME_PARSER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SCFP_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a condition on the edge that follows a reset cycle.
`define SCFP_ASSERT_AFTER_RESET(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) rst |=> cond) else $error(msg);

`endif

>>> hdl/scfp_pkg.sv
`default_nettype none

package scfp_pkg;

   // Frame characters
   localparam logic [7:0] CH_START   = 8'h24;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_MINUS   = 8'h2D;

   // Frame layout
   localparam int FRAME_DEPTH_DEFAULT = 17;
   localparam int FIELD_DIGITS        = 5;
   localparam int LEFT_SIGN_POS       = 1;
   localparam int RIGHT_SIGN_POS      = 8;
   localparam int BOOT_LEN            = 16;

   // Result width and decode constants
   localparam int TARGET_W = 23;
   localparam logic signed [TARGET_W-1:0] DIGIT_BIAS = 23'sd48;
   localparam logic signed [TARGET_W-1:0] DIGIT_WEIGHT [FIELD_DIGITS] =
      '{23'sd10000, 23'sd1000, 23'sd100, 23'sd10, 23'sd1};

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Buffer contents after reset: "$+12345,+12345\n", then zeros
   localparam logic [7:0] BOOT_FRAME [BOOT_LEN] = '{
      8'h24, 8'h2B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h2C,
      8'h2B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h0A, 8'h00
   };

   typedef logic [0:FIELD_DIGITS-1][7:0] digit_row_type;

   // Bytes of one completed frame that the decoder needs
   typedef struct packed {
      logic [7:0]    left_sign;
      digit_row_type left_digits;
      logic [7:0]    right_sign;
      digit_row_type right_digits;
   } frame_fields_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Reset value of one buffer entry
   function automatic logic [7:0] boot_byte(input int idx);
      logic [7:0] value;
      value = 8'h00;
      if (idx < BOOT_LEN) begin
         value = BOOT_FRAME[idx[3:0]];
      end
      return value;
   endfunction

endpackage

`default_nettype wire

>>> hdl/scfp_front.sv
`default_nettype none

module scfp_front
   import scfp_pkg::*;
#(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [7:0]       req_rx_byte,
   input  wire q_status_type     q_status,
   output logic                  req_stall,
   output logic                  push_valid,
   output frame_fields_type      push_data
);

   localparam int POS_W = $clog2(FRAME_DEPTH);

   logic [7:0]       frame_ff [FRAME_DEPTH];
   logic [7:0]       frame_in [FRAME_DEPTH];
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] wr_idx;
   logic             accept;

   // Hold off the sender while the queue is full
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // A start byte restarts the frame at entry 0
   assign wr_idx = (req_rx_byte == CH_START) ? '0 : pos_ff;

   // Buffer contents after this transfer
   always_comb begin
      for (int i = 0; i < FRAME_DEPTH; i++) begin
         frame_in[i] = (accept && wr_idx == POS_W'(i)) ? req_rx_byte : frame_ff[i];
      end
   end

   // Advance the write position, wrap after the last entry
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = (wr_idx == POS_W'(FRAME_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         for (int i = 0; i < FRAME_DEPTH; i++) begin
            frame_ff[i] <= boot_byte(i);
         end
      end else begin
         pos_ff <= pos_in;
         for (int i = 0; i < FRAME_DEPTH; i++) begin
            frame_ff[i] <= frame_in[i];
         end
      end
   end

   // Classify: a newline ends a frame that begins with a start byte
   assign push_valid = accept && req_rx_byte == CH_NEWLINE && frame_in[0] == CH_START;

   // Snapshot the sign and digit bytes of the frame
   always_comb begin
      push_data.left_sign  = frame_in[LEFT_SIGN_POS];
      push_data.right_sign = frame_in[RIGHT_SIGN_POS];
      for (int k = 0; k < FIELD_DIGITS; k++) begin
         push_data.left_digits[k]  = frame_in[LEFT_SIGN_POS + 1 + k];
         push_data.right_digits[k] = frame_in[RIGHT_SIGN_POS + 1 + k];
      end
   end

endmodule

`default_nettype wire

>>> hdl/scfp_queue.sv
`default_nettype none

module scfp_queue
   import scfp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire frame_fields_type  push_data,
   input  wire logic              pop_ready,
   output q_status_type           q_status,
   output frame_fields_type       head_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_fields_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop_ready && !q_status.empty;
   assign head_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed frame
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/scfp_back.sv
`default_nettype none

module scfp_back
   import scfp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire q_status_type            q_status,
   input  wire frame_fields_type        head_data,
   output logic                         pop_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [TARGET_W-1:0]   rsp_left_target,
   output logic signed [TARGET_W-1:0]   rsp_right_target,
   output logic                         rsp_stop_request
);

   // Weighted sum of five digit bytes, each taken as (byte - '0')
   function automatic logic signed [TARGET_W-1:0] field_sum(input digit_row_type row);
      logic signed [TARGET_W-1:0] acc;
      logic signed [TARGET_W-1:0] d;
      acc = '0;
      for (int k = 0; k < FIELD_DIGITS; k++) begin
         d   = signed'({{(TARGET_W-8){1'b0}}, row[k]}) - DIGIT_BIAS;
         acc = acc + d * DIGIT_WEIGHT[k];
      end
      return acc;
   endfunction

   logic                        sum_valid_ff, sum_valid_in;
   logic signed [TARGET_W-1:0]  left_sum_ff, right_sum_ff;
   logic                        left_neg_ff, right_neg_ff;
   logic                        out_valid_ff, out_valid_in;
   logic signed [TARGET_W-1:0]  left_ff, right_ff;
   logic                        stop_ff;
   logic                        out_ready;
   logic                        sum_ready;
   logic                        sum_load;
   logic                        out_load;

   // Stage enables: a stage loads when its contents move on or it is empty
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign sum_ready = !sum_valid_ff || out_ready;
   assign pop_ready = sum_ready;
   assign sum_load  = sum_ready && !q_status.empty;
   assign out_load  = out_ready && sum_valid_ff;

   always_comb begin
      sum_valid_in = sum_valid_ff;
      out_valid_in = out_valid_ff;
      if (sum_ready) begin
         sum_valid_in = !q_status.empty;
      end
      if (out_ready) begin
         out_valid_in = sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Sum stage: form both magnitudes, keep the sign flags
   always_ff @(posedge clock) begin
      if (sum_load) begin
         left_sum_ff  <= field_sum(head_data.left_digits);
         right_sum_ff <= field_sum(head_data.right_digits);
         left_neg_ff  <= (head_data.left_sign == CH_MINUS);
         right_neg_ff <= (head_data.right_sign == CH_MINUS);
      end
   end

   // Output stage: apply signs and flag a zero target
   always_ff @(posedge clock) begin
      if (out_load) begin
         left_ff  <= left_neg_ff ? -left_sum_ff : left_sum_ff;
         right_ff <= right_neg_ff ? -right_sum_ff : right_sum_ff;
         stop_ff  <= (left_sum_ff == '0) || (right_sum_ff == '0);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_left_target  = left_ff;
   assign rsp_right_target = right_ff;
   assign rsp_stop_request = stop_ff;

endmodule

`default_nettype wire

>>> hdl/speed_command_frame_parser.sv
// Speed command frame parser.
// req_ channel: one received serial byte per transfer (req_rx_byte). The
// bytes fill a frame buffer; a '$' restarts the frame at entry 0 and the
// write position wraps after the last entry. A newline that completes a
// frame whose entry 0 is '$' yields one result, any other byte yields none.
// rsp_ channel: signed left and right speed targets plus a stop flag that
// is set when either target is zero.
// Throughput: one byte per cycle. The front takes a byte every cycle unless
// its two-entry frame queue is full, and the back drains one frame a cycle
// unless rsp_stall holds it. A result moves from the queue to the sum stage
// and then the output stage, later when earlier results wait in the queue.
// Reset: the buffer reloads "$+12345,+12345\n" followed by zeros, the write
// position returns to 0, the queue and the output stages empty.
// Receiver stall: the result holds steady on the rsp_ ports; the sum stage
// and the queue absorb up to three more frames, then req_stall rises until
// room returns.
`default_nettype none

module speed_command_frame_parser
   import scfp_pkg::*;
#(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_rx_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [TARGET_W-1:0]   rsp_left_target,
   output logic signed [TARGET_W-1:0]   rsp_right_target,
   output logic                         rsp_stop_request
);

   q_status_type     q_status;
   logic             push_valid;
   frame_fields_type push_data;
   logic             pop_ready;
   frame_fields_type head_data;

   // Collect bytes and classify frame ends
   scfp_front #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .req_stall   (req_stall),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   // Decouple the front from the decoder
   scfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_ready  (pop_ready),
      .q_status   (q_status),
      .head_data  (head_data)
   );

   // Decode the speed fields
   scfp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_data        (head_data),
      .pop_ready        (pop_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_target  (rsp_left_target),
      .rsp_right_target (rsp_right_target),
      .rsp_stop_request (rsp_stop_request)
   );

endmodule

`default_nettype wire

>>> hdl/scfp_checker.sv
`default_nettype none
`include "speed_command_frame_parser_macros.svh"

module scfp_checker
   import scfp_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic [7:0]              req_rx_byte,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic signed [TARGET_W-1:0] rsp_left_target,
   input wire logic signed [TARGET_W-1:0] rsp_right_target,
   input wire logic                    rsp_stop_request
);

   // A stalled result stays offered
   `SCFP_ASSERT_ALWAYS(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "stalled result dropped")

   // The stop flag follows the two targets
   `SCFP_ASSERT_ALWAYS(a_stop_flag, clock, reset, rsp_valid |-> (rsp_stop_request == ((rsp_left_target == '0) || (rsp_right_target == '0))), "stop flag does not match targets")

   // Reset empties the output stage
   `SCFP_ASSERT_AFTER_RESET(a_reset_no_rsp, clock, reset, !rsp_valid, "result offered after reset")

   // Reset empties the queue, so the front takes bytes at once
   `SCFP_ASSERT_AFTER_RESET(a_reset_no_stall, clock, reset, !req_stall, "input stalled after reset")

endmodule

bind speed_command_frame_parser scfp_checker u_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
module tb_top
   import scfp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_DEPTH    = FRAME_DEPTH_DEFAULT;
   localparam int PHASE_ITEMS  = 400;
   localparam int DRAIN_CYCLES = 16;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic signed [TARGET_W-1:0] left_target;
      logic signed [TARGET_W-1:0] right_target;
      logic                       stop_request;
   } speed_cmd_type;

   typedef struct packed {
      logic [7:0]    rx;
      logic          has_literal;
      speed_cmd_type cmd;
   } stim_row_type;

   // Directed bytes; literal commands only where the frame is obvious
   localparam int DIRECTED_LEN = 22;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      // lone newline overwrites the leading '$', so nothing comes out
      '{CH_NEWLINE, 1'b0, '0},
      // most negative decimal left field, zero right field
      '{CH_START,   1'b0, '0},
      '{CH_MINUS,   1'b0, '0},
      '{CH_NINE,    1'b0, '0},
      '{CH_NINE,    1'b0, '0},
      '{CH_NINE,    1'b0, '0},
      '{CH_NINE,    1'b0, '0},
      '{CH_NINE,    1'b0, '0},
      '{CH_COMMA,   1'b0, '0},
      '{CH_PLUS,    1'b0, '0},
      '{CH_ZERO,    1'b0, '0},
      '{CH_ZERO,    1'b0, '0},
      '{CH_ZERO,    1'b0, '0},
      '{CH_ZERO,    1'b0, '0},
      '{CH_ZERO,    1'b0, '0},
      '{CH_NEWLINE, 1'b1, '{-23'sd99999, 23'sd0, 1'b1}},
      // short frame: stale bytes decoded, odd sign byte, newline as a digit
      '{CH_START,   1'b0, '0},
      '{8'hFF,      1'b0, '0},
      '{CH_NEWLINE, 1'b0, '0},
      '{CH_START,   1'b0, '0},
      '{8'h00,      1'b0, '0},
      '{CH_NEWLINE, 1'b0, '0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [TARGET_W-1:0] rsp_left_target;
   logic signed [TARGET_W-1:0] rsp_right_target;
   logic                       rsp_stop_request;

   // Shadow frame buffer and the commands still owed by the block
   logic [7:0]    frame_buf [BUF_DEPTH];
   int            wr_pos;
   speed_cmd_type pending_cmds [$];

   int sender_idle_pct = 0;
   int recv_idle_pct   = 0;
   int accepted_count  = 0;
   int mismatch_count  = 0;

   speed_command_frame_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_target  (rsp_left_target),
      .rsp_right_target (rsp_right_target),
      .rsp_stop_request (rsp_stop_request)
   );

   always #2 clock = ~clock;

   // Load the boot command into the shadow buffer
   function automatic void load_boot_frame();
      string boot_text;
      boot_text = "$+12345,+12345\n";
      for (int i = 0; i < BUF_DEPTH; i++) begin
         frame_buf[i] = (i < boot_text.len()) ? boot_text[i] : 8'h00;
      end
      wr_pos = 0;
   endfunction

   // Decode one sign-and-five-digit field; digits are weighted without checks
   function automatic int field_value(input int sign_pos);
      int acc;
      acc = 0;
      for (int k = 0; k < FIELD_DIGITS; k++) begin
         acc = acc * 10 + (int'(frame_buf[sign_pos + 1 + k]) - int'(CH_ZERO));
      end
      if (frame_buf[sign_pos] == CH_MINUS) begin
         acc = -acc;
      end
      return acc;
   endfunction

   // Store one byte and return the command it completes, if any
   function automatic bit absorb_rx_byte(input logic [7:0] rx, output speed_cmd_type cmd);
      int left_val;
      int right_val;
      cmd = '0;
      if (rx == CH_START) begin
         wr_pos = 0;
      end
      frame_buf[wr_pos] = rx;
      wr_pos = (wr_pos + 1 >= BUF_DEPTH) ? 0 : wr_pos + 1;
      if (rx != CH_NEWLINE || frame_buf[0] != CH_START) begin
         return 1'b0;
      end
      left_val  = field_value(LEFT_SIGN_POS);
      right_val = field_value(RIGHT_SIGN_POS);
      cmd.left_target  = left_val[TARGET_W-1:0];
      cmd.right_target = right_val[TARGET_W-1:0];
      cmd.stop_request = (left_val == 0 || right_val == 0);
      return 1'b1;
   endfunction

   // Mostly decimal digits, now and then any byte including the extremes
   function automatic logic [7:0] rand_digit();
      case ($urandom_range(9))
         0: return 8'($urandom_range(255));
         1: return $urandom_range(1) ? 8'hFF : 8'h00;
         default: return CH_ZERO + 8'($urandom_range(9));
      endcase
   endfunction

   function automatic logic [7:0] rand_sign();
      case ($urandom_range(9)) inside
         [0:3]: return CH_PLUS;
         [4:7]: return CH_MINUS;
         8: return CH_ZERO;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Drive one byte, wait for its transfer, then update the shadow state
   task automatic send_byte(input logic [7:0] rx, input bit has_literal,
                            input speed_cmd_type literal_cmd);
      speed_cmd_type predicted;
      bit            has_result;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_result = absorb_rx_byte(rx, predicted);
      if (has_literal) begin
         pending_cmds.push_back(literal_cmd);
      end else if (has_result) begin
         pending_cmds.push_back(predicted);
      end
      accepted_count++;
      @(negedge clock);
   endtask

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Compare each result transfer with the oldest owed command
   always @(posedge clock) begin
      speed_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected result: left %0d right %0d stop %0b", $time,
                     rsp_left_target, rsp_right_target, rsp_stop_request);
            mismatch_count++;
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_left_target !== want.left_target) begin
               $display("%0t: left_target expected %0d actual %0d", $time,
                        want.left_target, rsp_left_target);
               mismatch_count++;
            end
            if (rsp_right_target !== want.right_target) begin
               $display("%0t: right_target expected %0d actual %0d", $time,
                        want.right_target, rsp_right_target);
               mismatch_count++;
            end
            if (rsp_stop_request !== want.stop_request) begin
               $display("%0t: stop_request expected %0b actual %0b", $time,
                        want.stop_request, rsp_stop_request);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      logic [7:0] burst [$];
      int         kind;
      int         zero_side;
      int         run_len;
      int         phase_start;
      logic [7:0] rx;

      load_boot_frame();
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 29;
               recv_idle_pct   = 59;
            end
            1: begin
               sender_idle_pct = 59;
               recv_idle_pct   = 29;
            end
            default: begin
               sender_idle_pct = 0;
               recv_idle_pct   = 0;
            end
         endcase

         // Walk the directed rows once, at the start
         if (phase == 0) begin
            foreach (DIRECTED_ROWS[i]) begin
               send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].has_literal,
                         DIRECTED_ROWS[i].cmd);
            end
         end

         phase_start = accepted_count;
         while (accepted_count - phase_start < PHASE_ITEMS) begin
            burst.delete();
            kind = $urandom_range(99);
            if (kind < 60) begin
               // well-formed frame with random content
               zero_side = $urandom_range(7);
               burst.push_back(CH_START);
               for (int side = 0; side < 2; side++) begin
                  burst.push_back(rand_sign());
                  for (int k = 0; k < FIELD_DIGITS; k++) begin
                     burst.push_back(zero_side == side ? CH_ZERO : rand_digit());
                  end
                  if (side == 0) begin
                     burst.push_back(CH_COMMA);
                  end
               end
               burst.push_back(CH_NEWLINE);
            end else if (kind < 75) begin
               // short frame: the rest is read from stale entries
               run_len = $urandom_range(13);
               burst.push_back(CH_START);
               for (int k = 0; k < run_len; k++) begin
                  burst.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                         : rand_digit());
               end
               burst.push_back(CH_NEWLINE);
            end else if (kind < 85) begin
               // long run without start or newline, which can make the position wrap
               run_len = $urandom_range(40, 15);
               for (int k = 0; k < run_len; k++) begin
                  rx = 8'($urandom_range(255));
                  if (rx == CH_START || rx == CH_NEWLINE) begin
                     rx = rx + 8'd1;
                  end
                  burst.push_back(rx);
               end
               if ($urandom_range(1)) begin
                  burst.push_back(CH_NEWLINE);
               end
            end else begin
               // raw noise
               run_len = $urandom_range(8, 1);
               for (int k = 0; k < run_len; k++) begin
                  burst.push_back(8'($urandom_range(255)));
               end
            end
            foreach (burst[i]) begin
               send_byte(burst[i], 1'b0, '0);
            end
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then let the pipeline settle
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
